FILE: design/hwsem_pkg.sv
// Shared types and constants for the semaphore table unit.
// Used by hwsem_alu and the top level; no dependencies.
package hwsem_pkg;

  localparam int FUNC_W  = 3;
  localparam int SIDX_W  = 5;
  localparam int CPU_W   = 3;
  localparam int OWNER_W = 4;
  localparam int COUNT_W = 8;
  localparam int RANGE_W = 9;

  localparam logic [COUNT_W-1:0] NEST_MAX = {COUNT_W{1'b1}};

  typedef enum logic [FUNC_W-1:0] {
    FN_LOCK     = 3'd0,
    FN_UNLOCK   = 3'd1,
    FN_SPIN_ACQ = 3'd2,
    FN_SPIN_REL = 3'd3,
    FN_STATUS   = 3'd4
  } func_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic [OWNER_W-1:0] owner_code;
    logic               granted;
  } res_t;

endpackage

FILE: design/hwsem_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hwsem_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/hwsem_alu.sv
// Entry update for one semaphore request: next owner, count and reply.
// Depends on hwsem_pkg.
module hwsem_alu (
  input  logic [hwsem_pkg::FUNC_W-1:0] func,
  input  logic [hwsem_pkg::CPU_W-1:0]  cpu,
  input  logic                         idx_ok,
  input  logic                         cpu_ok,
  input  hwsem_pkg::entry_t            cur,
  output hwsem_pkg::entry_t            nxt,
  output logic                         we,
  output hwsem_pkg::res_t              res
);
  import hwsem_pkg::*;

  logic [OWNER_W-1:0] mine;
  entry_t             upd;

  assign mine = OWNER_W'(cpu) + OWNER_W'(1);

  always_comb begin
    upd = cur;
    case (func)
      FN_LOCK: begin
        if (cur.owner == '0) upd.owner = mine;
      end
      FN_UNLOCK: begin
        if (cur.owner == mine) upd.owner = '0;
      end
      FN_SPIN_ACQ: begin
        if (cur.owner == '0 || cur.owner == mine) begin
          upd.owner = mine;
          if (cur.count != NEST_MAX) upd.count = cur.count + COUNT_W'(1);
        end
      end
      FN_SPIN_REL: begin
        if (cur.owner == mine && cur.count != '0) begin
          upd.count = cur.count - COUNT_W'(1);
          if (cur.count == COUNT_W'(1)) upd.owner = '0;
        end
      end
      default: begin
        upd = cur;
      end
    endcase
  end

  always_comb begin
    we             = idx_ok && cpu_ok;
    nxt            = cpu_ok ? upd : cur;
    res.owner_code = idx_ok ? nxt.owner : '0;
    res.granted    = idx_ok && cpu_ok && (nxt.owner == mine);
  end

endmodule

FILE: design/hw_semaphore_with_nested_spinlock_unit.sv
// Semaphore table unit: owner code and nesting count per entry, one reply per request.
// Depends on hwsem_pkg, hwsem_ram and hwsem_alu.
//
// Takes one request per clock while the output is not stalled and returns its reply
// after acceptance through the table RAM read, then the update and write-back into the
// output register. A request that hits the entry written in the same clock takes
// the written value through a bypass register. Entries are unlocked right after
// reset through per-entry valid flops; no clearing pass is needed.
module hw_semaphore_with_nested_spinlock_unit #(
  parameter int NUM_SEMS = 32,
  parameter int NUM_CPUS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [hwsem_pkg::FUNC_W-1:0]  in_func,
  input  logic [hwsem_pkg::SIDX_W-1:0]  in_sem_index,
  input  logic [hwsem_pkg::CPU_W-1:0]   in_cpu_number,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [hwsem_pkg::OWNER_W-1:0] out_owner_code,
  output logic                          out_granted
);
  import hwsem_pkg::*;

  localparam int AW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int EW = $bits(entry_t);

  logic                in_accept;
  logic                out_free;
  logic                p_advance;
  logic [RANGE_W-1:0]  in_idx_ext;
  logic [AW-1:0]       in_addr;
  logic                in_idx_ok;
  logic                in_cpu_ok;

  logic                p_vld_r, p_vld_nxt;
  logic [FUNC_W-1:0]   p_func_r;
  logic [CPU_W-1:0]    p_cpu_r;
  logic [AW-1:0]       p_addr_r;
  logic                p_idx_ok_r;
  logic                p_cpu_ok_r;

  logic                fwd_r, fwd_nxt;
  entry_t              fwd_data_r;

  logic [NUM_SEMS-1:0] valid_r, valid_nxt;

  logic                out_vld_r, out_vld_nxt;
  res_t                out_res_r;

  logic [EW-1:0]       ram_rd;
  entry_t              cur;
  entry_t              alu_nxt;
  logic                alu_we;
  res_t                alu_res;
  logic                wr_en;

  assign in_accept  = in_valid && !in_stall;
  assign out_free   = !out_vld_r || !out_stall;
  assign p_advance  = p_vld_r && out_free;
  assign in_stall   = p_vld_r && !out_free;

  assign in_idx_ext = RANGE_W'(in_sem_index);
  assign in_addr    = in_idx_ext[AW-1:0];
  assign in_idx_ok  = in_idx_ext < RANGE_W'(NUM_SEMS);
  assign in_cpu_ok  = RANGE_W'(in_cpu_number) < RANGE_W'(NUM_CPUS);

  assign wr_en = p_advance && alu_we;

  hwsem_ram #(
    .WIDTH (EW),
    .DEPTH (NUM_SEMS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (p_addr_r),
    .wr_data (EW'(alu_nxt)),
    .rd_en   (in_accept),
    .rd_addr (in_addr),
    .rd_data (ram_rd)
  );

  always_comb begin
    if (fwd_r) begin
      cur = fwd_data_r;
    end else if (p_idx_ok_r && valid_r[p_addr_r]) begin
      cur = entry_t'(ram_rd);
    end else begin
      cur = '0;
    end
  end

  hwsem_alu u_alu (
    .func   (p_func_r),
    .cpu    (p_cpu_r),
    .idx_ok (p_idx_ok_r),
    .cpu_ok (p_cpu_ok_r),
    .cur    (cur),
    .nxt    (alu_nxt),
    .we     (alu_we),
    .res    (alu_res)
  );

  always_comb begin
    p_vld_nxt = p_vld_r;
    if (in_accept) begin
      p_vld_nxt = 1'b1;
    end else if (p_advance) begin
      p_vld_nxt = 1'b0;
    end

    fwd_nxt = fwd_r;
    if (in_accept) begin
      fwd_nxt = wr_en && (p_addr_r == in_addr);
    end else if (p_advance) begin
      fwd_nxt = 1'b0;
    end

    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[p_addr_r] = 1'b1;
    end

    out_vld_nxt = out_vld_r;
    if (p_advance) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_vld_r   <= 1'b0;
      fwd_r     <= 1'b0;
      valid_r   <= '0;
      out_vld_r <= 1'b0;
    end else begin
      p_vld_r   <= p_vld_nxt;
      fwd_r     <= fwd_nxt;
      valid_r   <= valid_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      p_func_r   <= in_func;
      p_cpu_r    <= in_cpu_number;
      p_addr_r   <= in_addr;
      p_idx_ok_r <= in_idx_ok;
      p_cpu_ok_r <= in_cpu_ok;
      fwd_data_r <= alu_nxt;
    end
    if (p_advance) begin
      out_res_r <= alu_res;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_owner_code = out_res_r.owner_code;
  assign out_granted    = out_res_r.granted;

  a_grant_has_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_granted |-> out_owner_code != '0)
    else $error("granted reply with unlocked owner code");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> p_vld_r && out_vld_r)
    else $error("input stalled with a free slot");

  a_bypass_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fwd_r |-> p_vld_r)
    else $error("bypass set with no request in flight");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> valid_r[$past(p_addr_r)])
    else $error("written entry not marked valid");

endmodule

FILE: verif/tb_top.sv
// Testbench for hw_semaphore_with_nested_spinlock_unit: random and directed requests with
// valid/stall idling on both sides, replies checked against a table model kept in the bench.
// Depends on hwsem_pkg and the unit under test.
module tb_top;
  import hwsem_pkg::*;

  localparam int SEM_COUNT   = 32;
  localparam int CPU_COUNT   = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_REQS = 210;

  localparam logic [FUNC_W-1:0] FN_RSVD_A = 3'd5;
  localparam logic [FUNC_W-1:0] FN_RSVD_B = 3'd6;
  localparam logic [FUNC_W-1:0] FN_RSVD_C = 3'd7;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SIDX_W-1:0] sem;
    logic [CPU_W-1:0]  cpu;
  } sem_req_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [SIDX_W-1:0]   in_sem_index = '0;
  logic [CPU_W-1:0]    in_cpu_number = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [OWNER_W-1:0]  out_owner_code;
  logic                out_granted;

  sem_req_t            pending_reqs[$];
  res_t                expected_replies[$];
  logic [OWNER_W-1:0]  owner_tab[SEM_COUNT];
  logic [COUNT_W-1:0]  nest_tab[SEM_COUNT];
  int                  queued_count = 0;
  int                  reqs_sent = 0;
  int                  replies_seen = 0;
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  int                  hold_left = 0;
  bit                  pressure_done = 1'b0;

  hw_semaphore_with_nested_spinlock_unit #(
    .NUM_SEMS(SEM_COUNT),
    .NUM_CPUS(CPU_COUNT)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_sem_index  (in_sem_index),
    .in_cpu_number (in_cpu_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_owner_code(out_owner_code),
    .out_granted   (out_granted)
  );

  always #5 clk = ~clk;

  function automatic res_t apply_request(sem_req_t r);
    logic [OWNER_W-1:0] mine;
    logic [OWNER_W-1:0] cur;
    res_t               res;
    res = '0;
    if (int'(r.sem) >= SEM_COUNT) return res;
    cur = owner_tab[r.sem];
    if (int'(r.cpu) >= CPU_COUNT) begin
      res.owner_code = cur;
      return res;
    end
    mine = OWNER_W'(r.cpu) + 1'b1;
    case (r.func)
      FN_LOCK: begin
        if (cur == '0) owner_tab[r.sem] = mine;
      end
      FN_UNLOCK: begin
        if (cur == mine) owner_tab[r.sem] = '0;
      end
      FN_SPIN_ACQ: begin
        if (cur == '0 || cur == mine) begin
          owner_tab[r.sem] = mine;
          if (nest_tab[r.sem] != NEST_MAX) nest_tab[r.sem] = nest_tab[r.sem] + 1'b1;
        end
      end
      FN_SPIN_REL: begin
        if (cur == mine && nest_tab[r.sem] != '0) begin
          nest_tab[r.sem] = nest_tab[r.sem] - 1'b1;
          if (nest_tab[r.sem] == '0) owner_tab[r.sem] = '0;
        end
      end
      default: ;
    endcase
    res.owner_code = owner_tab[r.sem];
    res.granted    = (owner_tab[r.sem] == mine);
    return res;
  endfunction

  function void push_req(logic [FUNC_W-1:0] f, logic [SIDX_W-1:0] s, logic [CPU_W-1:0] c);
    sem_req_t r;
    r.func = f;
    r.sem  = s;
    r.cpu  = c;
    pending_reqs.push_back(r);
    queued_count++;
  endfunction

  // driver: predict on each accepted beat, hold a stalled beat
  always @(posedge clk) begin : driver
    bit calm;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(apply_request({in_func, in_sem_index, in_cpu_number}));
        reqs_sent++;
      end
      calm = (reqs_sent >= 300 && reqs_sent < 400);
      if (in_valid && in_stall) begin
      end else if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= 32)) begin
        {in_func, in_sem_index, in_cpu_number} <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: check each reply beat, then pick the next stall
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        replies_seen++;
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: owner_code %0d granted %0d", out_owner_code, out_granted);
          mismatch_count++;
        end else begin
          want = expected_replies.pop_front();
          if (out_owner_code !== want.owner_code) begin
            $error("owner_code: expected %0d, got %0d", want.owner_code, out_owner_code);
            mismatch_count++;
          end
          if (out_granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, out_granted);
            mismatch_count++;
          end
        end
      end
      if (!pressure_done && replies_seen >= 150) begin
        pressure_done = 1'b1;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (replies_seen >= 320 && replies_seen < 420) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 32);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[hw_semaphore_with_nested_spinlock_unit] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int                 pick;
    int                 depth;
    int                 random_start;
    logic [SIDX_W-1:0]  sem;
    logic [CPU_W-1:0]   cpu;
    logic [CPU_W-1:0]   rival;

    for (int i = 0; i < SEM_COUNT; i++) begin
      owner_tab[i] = '0;
      nest_tab[i]  = '0;
    end

    // directed: every operation, ownership checks, zero-count release, unlock keeping count
    push_req(FN_STATUS,   5'd0,  3'd0);
    push_req(FN_LOCK,     5'd0,  3'd0);
    push_req(FN_LOCK,     5'd0,  3'd7);
    push_req(FN_UNLOCK,   5'd0,  3'd7);
    push_req(FN_UNLOCK,   5'd0,  3'd0);
    push_req(FN_SPIN_ACQ, 5'd31, 3'd7);
    push_req(FN_SPIN_ACQ, 5'd31, 3'd7);
    push_req(FN_SPIN_ACQ, 5'd31, 3'd3);
    push_req(FN_SPIN_REL, 5'd31, 3'd3);
    push_req(FN_SPIN_REL, 5'd31, 3'd7);
    push_req(FN_SPIN_REL, 5'd31, 3'd7);
    push_req(FN_STATUS,   5'd31, 3'd7);
    push_req(FN_LOCK,     5'd5,  3'd2);
    push_req(FN_SPIN_REL, 5'd5,  3'd2);
    push_req(FN_SPIN_ACQ, 5'd6,  3'd4);
    push_req(FN_UNLOCK,   5'd6,  3'd4);
    push_req(FN_LOCK,     5'd6,  3'd1);
    push_req(FN_SPIN_REL, 5'd6,  3'd1);
    push_req(FN_STATUS,   5'd6,  3'd1);
    push_req(FN_RSVD_A,   5'd0,  3'd1);
    push_req(FN_RSVD_B,   5'd31, 3'd6);
    push_req(FN_RSVD_C,   5'd5,  3'd2);

    // saturate one nesting count, then free it with the count left high
    repeat (258) push_req(FN_SPIN_ACQ, 5'd17, 3'd5);
    push_req(FN_STATUS,   5'd17, 3'd5);
    push_req(FN_SPIN_REL, 5'd17, 3'd5);
    push_req(FN_SPIN_REL, 5'd17, 3'd5);
    push_req(FN_UNLOCK,   5'd17, 3'd5);
    push_req(FN_SPIN_ACQ, 5'd17, 3'd2);
    push_req(FN_SPIN_REL, 5'd17, 3'd2);

    random_start = queued_count;
    while (queued_count - random_start < RANDOM_REQS) begin
      pick  = $urandom_range(99);
      sem   = SIDX_W'($urandom_range(SEM_COUNT - 1));
      cpu   = CPU_W'($urandom_range(CPU_COUNT - 1));
      rival = cpu ^ CPU_W'($urandom_range(1, CPU_COUNT - 1));
      if (pick < 35) begin
        push_req(FN_LOCK, sem, cpu);
        if ($urandom_range(1) == 1) push_req(FN_LOCK, sem, rival);
        if ($urandom_range(3) == 0) push_req(FN_UNLOCK, sem, rival);
        push_req(FN_STATUS, sem, cpu);
        push_req(FN_UNLOCK, sem, cpu);
      end else if (pick < 75) begin
        depth = $urandom_range(1, 4);
        repeat (depth) begin
          push_req(FN_SPIN_ACQ, sem, cpu);
          if ($urandom_range(3) == 0) push_req(FN_SPIN_ACQ, sem, rival);
        end
        push_req(FN_STATUS, sem, rival);
        repeat (depth + $urandom_range(1)) push_req(FN_SPIN_REL, sem, cpu);
      end else begin
        push_req(FUNC_W'($urandom_range(7)), sem, cpu);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (reqs_sent < queued_count) @(posedge clk);
    while (replies_seen < queued_count) @(posedge clk);
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[hw_semaphore_with_nested_spinlock_unit] OK");
    end else begin
      $display("[hw_semaphore_with_nested_spinlock_unit] ERROR");
    end
    $finish;
  end

endmodule
